// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- rtl/mcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpg_pkg
// Types and constants shared by the midpoint circle pixel generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // Widest radius supported, the default, and the widest offset register.
  localparam int MAX_RADIUS_BITS = 13;
  localparam int RADIUS_BITS_DEF = 12;
  localparam int SNAP_OFS_W      = MAX_RADIUS_BITS + 1;

  localparam int COORD_W  = 16;
  localparam int COLOUR_W = 16;
  localparam int SCREEN_W = 13;
  localparam int RAD_IN_W = 12;

  localparam int POINTS_PER_STEP = 8;
  localparam int IDX_W           = $clog2(POINTS_PER_STEP);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_STEP - 1);

  // Decision variable constants.
  localparam logic [15:0] DEC_INIT   = 16'd3;
  localparam logic [15:0] DEC_INC_X  = 16'd6;
  localparam logic [15:0] DEC_INC_XY = 16'd10;

  // Operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_LSB = 2;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd240;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd320;

  typedef struct packed {
    logic                       operation;
    logic signed [COORD_W-1:0]  centre_x;
    logic signed [COORD_W-1:0]  centre_y;
    logic [RAD_IN_W-1:0]        radius;
    logic [COLOUR_W-1:0]        pixel_colour;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [COLOUR_W-1:0]        point_colour;
    logic                       on_screen;
    logic                       last_of_step;
    logic                       circle_done;
  } point_t;

  // One step's worth of work handed from the circle state to the emitter.
  typedef struct packed {
    logic signed [SNAP_OFS_W-1:0] x;
    logic signed [SNAP_OFS_W-1:0] y;
    logic [COORD_W-1:0]           centre_x;
    logic [COORD_W-1:0]           centre_y;
    logic [COLOUR_W-1:0]          colour;
    logic                         done;
  } snap_t;

endpackage

// ----- rtl/mcpg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mcpg_cfg_regs
// APB-style register file holding the screen size.
// ----------------------------------------------------------------------------
module mcpg_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcpg_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mcpg_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mcpg_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [mcpg_pkg::SCREEN_W-1:0]        screen_width,
  output logic [mcpg_pkg::SCREEN_W-1:0]        screen_height
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[mcpg_pkg::CFG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= mcpg_pkg::SCREEN_WIDTH_RST;
      screen_height <= mcpg_pkg::SCREEN_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mcpg_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[mcpg_pkg::SCREEN_W-1:0];
        mcpg_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[mcpg_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcpg_pkg::REG_SCREEN_WIDTH:  prdata = mcpg_pkg::CFG_DATA_W'(screen_width);
      mcpg_pkg::REG_SCREEN_HEIGHT: prdata = mcpg_pkg::CFG_DATA_W'(screen_height);
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/mcpg_circle.sv -----
// ----------------------------------------------------------------------------
// mcpg_circle
// Circle state: centre, colour, offsets and midpoint decision variable.
// ----------------------------------------------------------------------------
module mcpg_circle #(
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  mcpg_pkg::in_item_t item,
  output logic               snap_load,
  output mcpg_pkg::snap_t    snap
);

  localparam int OFS_W = RADIUS_BITS + 1;

  logic                    active;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;
  logic [15:0]             decision;
  logic [15:0]             held_centre_x;
  logic [15:0]             held_centre_y;
  logic [15:0]             held_colour;

  logic [mcpg_pkg::MAX_RADIUS_BITS-1:0] rad_wide;
  logic [OFS_W-1:0]        r_ofs;
  logic [15:0]             dec_start;
  logic [15:0]             x16;
  logic [15:0]             y16;
  logic [15:0]             decision_next;
  logic signed [OFS_W-1:0] offset_x_next;
  logic signed [OFS_W-1:0] offset_y_next;
  logic                    done;
  logic                    is_start;

  assign is_start = (item.operation == mcpg_pkg::OP_START);

  // Keep only the low RADIUS_BITS of the radius.
  assign rad_wide  = mcpg_pkg::MAX_RADIUS_BITS'(item.radius);
  assign r_ofs     = {1'b0, rad_wide[RADIUS_BITS-1:0]};
  assign dec_start = mcpg_pkg::DEC_INIT - (16'(r_ofs) << 1);

  assign x16 = 16'(offset_x);
  assign y16 = 16'(offset_y);

  always_comb begin
    offset_x_next = offset_x + OFS_W'(1);
    if (decision[15]) begin
      decision_next = decision + (x16 << 2) + mcpg_pkg::DEC_INC_X;
      offset_y_next = offset_y;
    end else begin
      decision_next = decision + ((x16 - y16) << 2) + mcpg_pkg::DEC_INC_XY;
      offset_y_next = offset_y - OFS_W'(1);
    end
  end

  assign done      = (offset_x_next > offset_y_next);
  assign snap_load = accept && !is_start && active;

  assign snap.x        = mcpg_pkg::SNAP_OFS_W'(offset_x);
  assign snap.y        = mcpg_pkg::SNAP_OFS_W'(offset_y);
  assign snap.centre_x = held_centre_x;
  assign snap.centre_y = held_centre_y;
  assign snap.colour   = held_colour;
  assign snap.done     = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      held_centre_x <= '0;
      held_centre_y <= '0;
      held_colour   <= '0;
    end else if (accept && is_start) begin
      active        <= 1'b1;
      offset_x      <= '0;
      offset_y      <= signed'(r_ofs);
      decision      <= dec_start;
      held_centre_x <= item.centre_x;
      held_centre_y <= item.centre_y;
      held_colour   <= item.pixel_colour;
    end else if (snap_load) begin
      active   <= !done;
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
    end
  end

endmodule

// ----- rtl/mcpg_emitter.sv -----
// ----------------------------------------------------------------------------
// mcpg_emitter
// Step register and point output register; sends eight points per step.
// ----------------------------------------------------------------------------
module mcpg_emitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  mcpg_pkg::snap_t               snap,
  input  logic [mcpg_pkg::SCREEN_W-1:0] screen_width,
  input  logic [mcpg_pkg::SCREEN_W-1:0] screen_height,
  output logic                          take,
  output logic                          point_valid,
  input  logic                          point_ready,
  output mcpg_pkg::point_t              point
);

  logic                           busy;
  logic [mcpg_pkg::IDX_W-1:0]     idx;
  mcpg_pkg::snap_t                step;

  logic                                 advance;
  logic                                 at_last;
  logic signed [mcpg_pkg::SNAP_OFS_W-1:0] a;
  logic signed [mcpg_pkg::SNAP_OFS_W-1:0] b;
  logic signed [mcpg_pkg::SNAP_OFS_W-1:0] da;
  logic signed [mcpg_pkg::SNAP_OFS_W-1:0] db;
  mcpg_pkg::point_t                     point_next;

  assign advance = busy && (!point_valid || point_ready);
  assign at_last = (idx == mcpg_pkg::LAST_IDX);
  assign take    = !busy || (advance && at_last);

  // Point order: swap on the upper half, negate by the two low index bits.
  always_comb begin
    a  = idx[2] ? step.y : step.x;
    b  = idx[2] ? step.x : step.y;
    da = idx[0] ? -a : a;
    db = idx[1] ? -b : b;
    point_next.point_x      = step.centre_x + 16'(da);
    point_next.point_y      = step.centre_y + 16'(db);
    point_next.point_colour = step.colour;
    point_next.on_screen    = (point_next.point_x < {3'b000, screen_width}) &&
                              (point_next.point_y < {3'b000, screen_height});
    point_next.last_of_step = at_last;
    point_next.circle_done  = at_last && step.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance) begin
      busy <= !at_last;
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (advance) begin
      point_valid <= 1'b1;
    end else if (point_ready) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point <= point_next;
    end
  end

endmodule

// ----- rtl/midpoint_circle_pixel_generator_unit.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_pixel_generator_unit
// Outline circle rasterizer using the integer midpoint decision variable.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): a start transfer latches centre,
//   radius and colour and sends nothing; a step transfer sends the eight
//   symmetric points of the current offsets on the point channel and advances
//   the circle. A step with no circle active sends nothing.
//   point channel (point_valid/point_ready/point): one point per transfer, with
//   on_screen, last_of_step on the eighth, and circle_done when the circle ends.
//   Screen size is set over the APB-style port (width at 0x0, height at 0x4).
// Step flow:
//   A step transfer loads the step register; its points then leave one per
//   cycle through the single point register while point_ready is high.
//   The next step is taken in the cycle its predecessor's eighth point is
//   loaded, so steps stream back to back with no gap between them.
// Reset:
//   clears the circle (no circle active), empties the point register and sets
//   the screen to 240 x 320.
// Stall:
//   while point_ready is low the point register holds, the emitter waits and
//   item_ready stays low once the current step is in progress.
// ----------------------------------------------------------------------------
module midpoint_circle_pixel_generator_unit #(
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Item channel
  input  logic                             item_valid,
  output logic                             item_ready,
  input  mcpg_pkg::in_item_t               item,
  // Point channel
  output logic                             point_valid,
  input  logic                             point_ready,
  output mcpg_pkg::point_t                 point,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcpg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mcpg_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mcpg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic                          item_accept;
  logic                          snap_load;
  mcpg_pkg::snap_t               snap;
  logic [mcpg_pkg::SCREEN_W-1:0] screen_width;
  logic [mcpg_pkg::SCREEN_W-1:0] screen_height;

  // Transfer on the item channel.
  assign item_accept = item_valid && item_ready;

  mcpg_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  // Circle state advances at the step transfer and hands the pre-step
  // offsets to the emitter in the same edge.
  mcpg_circle #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_circle (
    .clk       (clk),
    .rst       (rst),
    .accept    (item_accept),
    .item      (item),
    .snap_load (snap_load),
    .snap      (snap)
  );

  // Emitter drives item_ready: free, or finishing its eighth point now.
  mcpg_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load          (snap_load),
    .snap          (snap),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .take          (item_ready),
    .point_valid   (point_valid),
    .point_ready   (point_ready),
    .point         (point)
  );

endmodule

// ----- rtl/mcpg_checker.sv -----
// ----------------------------------------------------------------------------
// mcpg_checker
// Port-level checks for the circle pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcpg_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               point_valid,
  input logic               point_ready,
  input mcpg_pkg::point_t   point
);

  `ASSERT_CLK(a_point_hold, clk, rst, point_valid && !point_ready |=> point_valid && $stable(point), "point changed while stalled")
  `ASSERT_CLK(a_done_on_last, clk, rst, point_valid && point.circle_done |-> point.last_of_step, "circle_done without last_of_step")
  `ASSERT_CLK(a_busy_fills, clk, rst, !item_ready && !point_valid |=> point_valid, "emitter busy but no point produced")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !point_valid, "point register not empty after reset")

endmodule

bind midpoint_circle_pixel_generator_unit mcpg_checker u_checker (.*);
